// File: rtl/btpc_pkg.sv
// shared types and constants for the barometric compensation block
package btpc_pkg;

    localparam int unsigned CAL_W     = 48;
    localparam int unsigned RAW_W     = 20;
    localparam int unsigned NUM_REGS  = 4;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned DIV_BITS  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSA = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSB = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSC = 8'd3;

    // item carried from the front part to the back part
    typedef struct packed {
        logic signed [31:0] fine;
        logic        [RAW_W-1:0] adc_p;
    } t_item;

    // calibration words
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_calib;

endpackage

// File: rtl/btpc_front.sv
// front part: temperature compensation, three registered stages
module btpc_front
    import btpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAW_W-1:0]  i_adc_t,
    input  logic [RAW_W-1:0]  i_adc_p,
    input  t_calib            i_cal,
    output logic              o_valid,
    output t_item             o_item
);

    logic        [2:0]  r_vld;
    logic signed [31:0] r_a, r_b;
    logic signed [31:0] r_tv1, r_bb;
    logic signed [31:0] r_fine;
    logic [RAW_W-1:0]   r_p0, r_p1, r_p2;

    logic signed [31:0] n_a, n_b, n_tv1, n_bb, n_t2m, n_fine;

    // temperature arithmetic, 32-bit wrapping
    always_comb begin
        n_a   = $signed({15'd0, i_adc_t[19:3]}) - $signed({15'd0, i_cal.t1, 1'b0});
        n_b   = $signed({16'd0, i_adc_t[19:4]}) - $signed({16'd0, i_cal.t1});
        n_tv1 = (r_a * 32'(i_cal.t2)) >>> 11;
        n_bb  = (r_b * r_b) >>> 12;
        n_t2m = (r_bb * 32'(i_cal.t3)) >>> 14;
        n_fine = r_tv1 + n_t2m;
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_p0   <= i_adc_p;
            r_tv1  <= n_tv1;
            r_bb   <= n_bb;
            r_p1   <= r_p0;
            r_fine <= n_fine;
            r_p2   <= r_p1;
        end
    end

    assign o_valid      = r_vld[2];
    assign o_item.fine  = r_fine;
    assign o_item.adc_p = r_p2;

endmodule

// File: rtl/btpc_fifo.sv
// short queue between the front and back parts
module btpc_fifo
    import btpc_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= AW'((r_wp + 1'b1) % DEPTH);
            if (i_pop)  r_rp <= AW'((r_rp + 1'b1) % DEPTH);
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

// File: rtl/btpc_div.sv
// pipelined signed 64-bit divider, one quotient bit per stage
module btpc_div
    import btpc_pkg::*;
#(
    parameter int unsigned SIDE_W = 8
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_num,
    input  logic [63:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [63:0]       o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned N = DIV_BITS;

    logic [N:0]        r_vld;
    logic [63:0]       r_rem [N+1];
    logic [63:0]       r_q   [N+1];
    logic [63:0]       r_d   [N+1];
    logic              r_neg [N+1];
    logic [SIDE_W-1:0] r_sd  [N+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_valid};
        end
    end

    // stage 0: magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_q[0]   <= i_num[63] ? 64'(-i_num) : i_num;
            r_d[0]   <= i_den[63] ? 64'(-i_den) : i_den;
            r_neg[0] <= i_num[63] ^ i_den[63];
            r_sd[0]  <= i_side;
        end
    end

    // restoring stages
    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [64:0] w_trial;
        logic [64:0] w_sub;
        assign w_trial = {r_rem[s], r_q[s][63]};
        assign w_sub   = w_trial - {1'b0, r_d[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_sub[64]) begin
                    r_rem[s+1] <= w_sub[63:0];
                    r_q[s+1]   <= {r_q[s][62:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_trial[63:0];
                    r_q[s+1]   <= {r_q[s][62:0], 1'b0};
                end
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
                r_sd[s+1]  <= r_sd[s];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_quot  = r_neg[N] ? 64'(-r_q[N]) : r_q[N];
    assign o_side  = r_sd[N];

endmodule

// File: rtl/btpc_back.sv
// back part: 64-bit pressure compensation with divider
module btpc_back
    import btpc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_item         i_item,
    input  t_calib        i_cal,
    output logic          o_valid,
    output logic [23:0]   o_centi,
    output logic [31:0]   o_fine,
    output logic [31:0]   o_press,
    output logic          o_dz
);

    localparam int unsigned SIDE_W = 33;

    // stage registers
    logic [5:0] r_vld;
    logic signed [32:0] r_v1;
    logic signed [63:0] r_v1sq, r_v1p5, r_v1p2;
    logic signed [63:0] r_a6, r_a3, r_v2b, r_v1b;
    logic signed [63:0] r_v2, r_v1c;
    logic signed [63:0] r_var1, r_num0;
    logic signed [63:0] r_var1f, r_num;
    logic signed [31:0] r_f [6];
    logic [RAW_W-1:0]   r_ap [4];

    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign p1 = $signed({48'd0, i_cal.p1});
    assign p2 = 64'(i_cal.p2);
    assign p3 = 64'(i_cal.p3);
    assign p4 = 64'(i_cal.p4);
    assign p5 = 64'(i_cal.p5);
    assign p6 = 64'(i_cal.p6);
    assign p7 = 64'(i_cal.p7);
    assign p8 = 64'(i_cal.p8);
    assign p9 = 64'(i_cal.p9);

    logic signed [32:0] n_v1;
    logic signed [63:0] n_p;
    assign n_v1 = 33'(i_item.fine) - 33'sd128000;
    assign n_p  = 64'sd1048576 - $signed({44'd0, r_ap[3]});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // divisor and numerator formation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1    <= n_v1;
            r_f[0]  <= i_item.fine;
            r_ap[0] <= i_item.adc_p;
            r_v1sq  <= 64'(r_v1) * 64'(r_v1);
            r_v1p5  <= 64'(r_v1) * p5;
            r_v1p2  <= 64'(r_v1) * p2;
            r_a6    <= r_v1sq * p6;
            r_a3    <= r_v1sq * p3;
            r_v2b   <= (r_v1p5 <<< 17) + (p4 <<< 35);
            r_v1b   <= (r_v1p2 <<< 12);
            r_v2    <= r_a6 + r_v2b;
            r_v1c   <= (r_a3 >>> 8) + r_v1b;
            r_var1  <= r_v1c + (64'sd1 <<< 47);
            r_num0  <= (n_p <<< 31) - r_v2;
            r_var1f <= (r_var1 * p1) >>> 33;
            r_num   <= r_num0 * 64'sd3125;
            for (int k = 1; k < 6; k++) r_f[k] <= r_f[k-1];
            for (int k = 1; k < 4; k++) r_ap[k] <= r_ap[k-1];
        end
    end

    // divider, zero divisor flag travels alongside
    logic        w_dz;
    logic [63:0] w_quot;
    logic [SIDE_W-1:0] w_side;
    logic        w_dvld;
    assign w_dz = (r_var1f == 64'sd0);

    btpc_div #(.SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld[5]),
        .i_num   (r_num),
        .i_den   (w_dz ? 64'd1 : r_var1f),
        .i_side  ({w_dz, r_f[5]}),
        .o_valid (w_dvld),
        .o_quot  (w_quot),
        .o_side  (w_side)
    );

    // post-division correction
    logic [5:0] r_pv;
    logic signed [63:0] r_q, r_qs, r_pp, r_qsb, r_t1, r_t2, r_t12, r_t12d;
    logic [63:0] r_m0;
    logic [31:0] r_m1, r_m2;
    logic signed [63:0] r_prod, r_sum, r_fin;
    logic [32:0] r_s [6];
    logic signed [31:0] w_tc;
    assign w_tc = (r_s[5][31:0] * 32'sd5 + 32'sd128) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (i_en) begin
            r_pv <= {r_pv[4:0], w_dvld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage a: p and p>>13
            r_q    <= w_quot;
            r_qs   <= $signed(w_quot) >>> 13;
            r_s[0] <= w_side;
            // stage b: p9 times p>>13, and the p8 term
            r_pp   <= p9 * r_qs;
            r_qsb  <= r_qs;
            r_t2   <= (p8 * r_q) >>> 19;
            r_t1   <= r_q;
            // stage c: 32-bit partial products of the wrapped 64-bit product
            r_m0   <= 64'(r_pp[31:0] * r_qsb[31:0]);
            r_m1   <= 32'(r_pp[63:32] * r_qsb[31:0]);
            r_m2   <= 32'(r_pp[31:0] * r_qsb[63:32]);
            r_t12  <= r_t1 + r_t2;
            // stage d: low 64 bits of the product
            r_prod <= $signed(r_m0 + {32'(r_m1 + r_m2), 32'd0});
            r_t12d <= r_t12;
            // stage e: sums
            r_sum  <= r_t12d + (r_prod >>> 25);
            // stage f: scale and offset
            r_fin  <= (r_sum >>> 8) + (p7 <<< 4);
            for (int k = 1; k < 6; k++) r_s[k] <= r_s[k-1];
        end
    end

    // saturation and output
    logic [31:0] w_sat;
    always_comb begin
        if (r_s[5][32])
            w_sat = '0;
        else if (r_fin[63])
            w_sat = '0;
        else if (r_fin[63:32] != '0)
            w_sat = 32'hFFFF_FFFF;
        else
            w_sat = r_fin[31:0];
    end

    assign o_valid = r_pv[5];
    assign o_centi = w_tc[23:0];
    assign o_fine  = r_s[5][31:0];
    assign o_press = w_sat;
    assign o_dz    = r_s[5][32];

endmodule

// File: rtl/baro_temp_pressure_compensate.sv
// Barometric temperature and pressure compensation, one sample pair per cycle
// when not stalled. Stages: 3 front stages, the queue, 6 pressure stages,
// 65 divider stages, 6 final stages. Throughput: one item per cycle when not
// stalled; an 8-entry queue covers the credit loop, and the back pipeline
// advances whenever the output slot is empty or taken.
// Reset (synchronous, active low) clears valid bits, queue pointers and calibration.
module baro_temp_pressure_compensate
    import btpc_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_temperature [19:0], raw_pressure [39:20], zero fill [47:40]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temperature_centi [23:0], fine_temperature [55:24],
    // pressure_q24_8 [87:56], divide_by_zero [88], zero fill [95:89]
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CAL_W-1:0]     i_cfg_data
);

    logic [CAL_W-1:0] r_cal [NUM_REGS];
    t_calib w_cal;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_cal[k] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP:   r_cal[0] <= i_cfg_data;
                REG_PRESSA: r_cal[1] <= i_cfg_data;
                REG_PRESSB: r_cal[2] <= i_cfg_data;
                REG_PRESSC: r_cal[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    assign w_cal.t1 = r_cal[0][15:0];
    assign w_cal.t2 = r_cal[0][31:16];
    assign w_cal.t3 = r_cal[0][47:32];
    assign w_cal.p1 = r_cal[1][15:0];
    assign w_cal.p2 = r_cal[1][31:16];
    assign w_cal.p3 = r_cal[1][47:32];
    assign w_cal.p4 = r_cal[2][15:0];
    assign w_cal.p5 = r_cal[2][31:16];
    assign w_cal.p6 = r_cal[2][47:32];
    assign w_cal.p7 = r_cal[3][15:0];
    assign w_cal.p8 = r_cal[3][31:16];
    assign w_cal.p9 = r_cal[3][47:32];

    // front part never stalls; queue credit bounds in-flight items
    localparam int unsigned CW = $clog2(DEPTH+1);
    logic       f_valid;
    t_item      f_item;
    logic       q_empty, q_pop;
    t_item      q_data;
    logic [CW-1:0] q_count;
    logic [CW:0]   w_inflight;
    logic [2:0]    r_fv;

    assign w_inflight    = {1'b0, q_count} + (CW+1)'($countones(r_fv));
    assign s_axis_tready = (w_inflight < (CW+1)'(DEPTH));

    btpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_valid (s_axis_tvalid && s_axis_tready),
        .i_adc_t (s_axis_tdata[19:0]),
        .i_adc_p (s_axis_tdata[39:20]),
        .i_cal   (w_cal),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    // track front occupancy locally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= '0;
        else          r_fv <= {r_fv[1:0], s_axis_tvalid && s_axis_tready};
    end

    btpc_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_item),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // back pipeline advances when the output slot is empty or taken
    logic b_en, b_valid;
    logic [23:0] b_centi;
    logic [31:0] b_fine, b_press;
    logic b_dz;
    assign b_en  = !b_valid || m_axis_tready;
    assign q_pop = b_en && !q_empty;

    btpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_en),
        .i_valid (q_pop),
        .i_item  (q_data),
        .i_cal   (w_cal),
        .o_valid (b_valid),
        .o_centi (b_centi),
        .o_fine  (b_fine),
        .o_press (b_press),
        .o_dz    (b_dz)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {7'd0, b_dz, b_press, b_fine, b_centi};

endmodule

// File: rtl/btpc_checker.sv
// port-level checker for the compensation block and its bind
module btpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // zero divisor forces zero pressure
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[88] |-> m_axis_tdata[87:56] == 32'd0)
        else $error("pressure not zero on zero divisor");

    // fill bits stay zero
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:89] == 7'd0)
        else $error("fill bits set");

endmodule

bind baro_temp_pressure_compensate btpc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
